// ===== hdl/pvs_pkg.sv =====
// ----------------------------------------------------------------------------
// pvs_pkg
// Shared widths, constants and types of the variance / standard deviation core.
// ----------------------------------------------------------------------------
package pvs_pkg;

  // Set length limit and sample width
  localparam int unsigned MaxSamples = 1024;
  localparam int unsigned SampleW    = 16;

  // Accumulator widths
  localparam int unsigned CntW = 11;  // holds MaxSamples itself
  localparam int unsigned SumW = 27;  // signed running sum
  localparam int unsigned SqW  = 41;  // running sum of squares
  localparam int unsigned MagW = SumW - 1;

  // Back-end arithmetic widths
  localparam int unsigned FracW  = 8;               // fraction bits of the results
  localparam int unsigned ProdW  = CntW + SqW;      // N*S2
  localparam int unsigned DW     = 51;              // N*S2 - S1^2, never negative
  localparam int unsigned DivInW = DW + 2 * FracW;  // D << 16
  localparam int unsigned NnW    = 2 * CntW;        // N*N and the partial remainder
  localparam int unsigned QuotW  = 47;              // floor(65536*D/N^2), odd width
  localparam int unsigned VarW   = QuotW - FracW;
  localparam int unsigned StdW   = 24;
  localparam int unsigned ItW    = 7;               // counts division steps

  // Set totals handed from the front end to the back end
  typedef struct packed {
    logic [CntW-1:0]        count;
    logic signed [SumW-1:0] sum;
    logic [SqW-1:0]         sq_sum;
    logic                   overflow;
  } set_sums_t;

  // Queue status seen by both sides
  typedef struct packed {
    logic full;
    logic empty;
  } queue_stat_t;

endpackage

// ===== hdl/pvs_if.sv =====
// ----------------------------------------------------------------------------
// pvs_if
// Valid/ready channels for sample words and result words.
// ----------------------------------------------------------------------------

// Sample channel
interface pvs_in_if;
  logic                                valid;
  logic                                ready;
  logic signed [pvs_pkg::SampleW-1:0]  sample;
  logic                                last_sample;

  modport source (output valid, sample, last_sample, input ready);
  modport sink   (input valid, sample, last_sample, output ready);
endinterface

// Result channel
interface pvs_out_if;
  logic                        valid;
  logic                        ready;
  logic [pvs_pkg::VarW-1:0]    variance_scaled;
  logic [pvs_pkg::StdW-1:0]    std_dev_scaled;
  logic [pvs_pkg::CntW-1:0]    sample_count;
  logic                        too_many;

  modport source (output valid, variance_scaled, std_dev_scaled, sample_count, too_many,
                  input ready);
  modport sink   (input valid, variance_scaled, std_dev_scaled, sample_count, too_many,
                  output ready);
endinterface

// ===== hdl/pvs_front.sv =====
// ----------------------------------------------------------------------------
// pvs_front
// Accumulates count, sum and sum of squares of one set; hands totals on at the
// last sample.
// ----------------------------------------------------------------------------
module pvs_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  pvs_in_if.sink              in_i,
  input  pvs_pkg::queue_stat_t q_stat_i,
  output logic                push_o,
  output pvs_pkg::set_sums_t  push_data_o
);
  import pvs_pkg::*;

  logic [CntW-1:0]              cnt_q, cnt_d;
  logic signed [SumW-1:0]       sum_q, sum_d;
  logic [SqW-1:0]               sq_q, sq_d;
  logic                         ovf_q, ovf_d;
  logic signed [2*SampleW-1:0]  sq_s;
  logic                         accept;
  logic                         room;

  // Take a word whenever the queue can hold a finished set
  assign in_i.ready = ~q_stat_i.full;
  assign accept     = in_i.valid & in_i.ready;

  // Samples past the limit are dropped and flagged
  assign room = (cnt_q < CntW'(MaxSamples));
  assign sq_s = in_i.sample * in_i.sample;

  always_comb begin
    cnt_d = cnt_q;
    sum_d = sum_q;
    sq_d  = sq_q;
    ovf_d = ovf_q;
    if (room) begin
      cnt_d = cnt_q + CntW'(1);
      sum_d = sum_q + SumW'(in_i.sample);
      sq_d  = sq_q + SqW'(unsigned'(sq_s));
    end else begin
      ovf_d = 1'b1;
    end
  end

  // Totals including the closing sample
  assign push_o      = accept & in_i.last_sample;
  assign push_data_o = '{count: cnt_d, sum: sum_d, sq_sum: sq_d, overflow: ovf_d};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      sum_q <= '0;
      sq_q  <= '0;
      ovf_q <= 1'b0;
    end else if (accept) begin
      if (in_i.last_sample) begin
        cnt_q <= '0;
        sum_q <= '0;
        sq_q  <= '0;
        ovf_q <= 1'b0;
      end else begin
        cnt_q <= cnt_d;
        sum_q <= sum_d;
        sq_q  <= sq_d;
        ovf_q <= ovf_d;
      end
    end
  end

  // Count never passes the limit
  a_cnt_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(MaxSamples))
    else $error("sample count above limit");

  // A dropped sample always leaves the overflow flag set
  a_ovf_set: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && !room && !in_i.last_sample) |=> ovf_q)
    else $error("dropped sample not flagged");

endmodule

// ===== hdl/pvs_queue.sv =====
// ----------------------------------------------------------------------------
// pvs_queue
// Two-entry queue of set totals between the front and back ends.
// ----------------------------------------------------------------------------
module pvs_queue (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  pvs_pkg::set_sums_t   push_data_i,
  input  logic                 pop_i,
  output pvs_pkg::set_sums_t   pop_data_o,
  output pvs_pkg::queue_stat_t stat_o
);
  import pvs_pkg::*;

  set_sums_t  mem_q [2];
  logic       wr_q;
  logic       rd_q;
  logic [1:0] fill_q;

  assign stat_o.full  = (fill_q == 2'd2);
  assign stat_o.empty = (fill_q == 2'd0);
  assign pop_data_o   = mem_q[rd_q];

  // Storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

  // Pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q   <= 1'b0;
      rd_q   <= 1'b0;
      fill_q <= 2'd0;
    end else begin
      if (push_i) begin
        wr_q <= ~wr_q;
      end
      if (pop_i) begin
        rd_q <= ~rd_q;
      end
      case ({push_i, pop_i})
        2'b10:   fill_q <= fill_q + 2'd1;
        2'b01:   fill_q <= fill_q - 2'd1;
        default: fill_q <= fill_q;
      endcase
    end
  end

  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> (fill_q != 2'd2 || pop_i))
    else $error("push into full queue");

  a_no_underrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> fill_q != 2'd0)
    else $error("pop from empty queue");

endmodule

// ===== hdl/pvs_back.sv =====
// ----------------------------------------------------------------------------
// pvs_back
// Per-set arithmetic: D = N*S2 - S1^2, bit-serial divide by N^2, bit-serial
// square root, result register.
// ----------------------------------------------------------------------------
module pvs_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  pvs_pkg::set_sums_t   pop_data_i,
  input  pvs_pkg::queue_stat_t q_stat_i,
  output logic                 pop_o,
  pvs_out_if.source            out_o
);
  import pvs_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_SUB,
    ST_DIV,
    ST_SQRT,
    ST_DONE
  } state_e;

  state_e              state_q;
  set_sums_t           set_q;
  logic [ProdW-1:0]    p1_q;
  logic [2*MagW-1:0]   p2_q;
  logic [NnW-1:0]      nn_q;
  logic [DivInW-1:0]   div_q;
  logic [NnW-1:0]      rem_q;
  logic [QuotW-1:0]    quo_q;
  logic [ItW-1:0]      it_q;
  logic [QuotW-1:0]    x_q;
  logic [QuotW:0]      res_q;
  logic [QuotW-1:0]    bit_q;
  logic                out_vld_q;
  logic [VarW-1:0]     var_q;
  logic [StdW-1:0]     std_q;
  logic [CntW-1:0]     cnt_out_q;
  logic                ovf_out_q;

  logic [SumW-1:0]     abs_sum;
  logic [NnW-1:0]      trial;
  logic                div_ge;
  logic [NnW-1:0]      rem_d;
  logic [QuotW-1:0]    quo_d;
  logic [QuotW:0]      sq_try;
  logic                sq_ge;
  logic                out_free;

  // |S1|
  assign abs_sum = set_q.sum[SumW-1] ? SumW'(-set_q.sum) : SumW'(set_q.sum);

  // One restoring division step
  assign trial  = {rem_q[NnW-2:0], div_q[DivInW-1]};
  assign div_ge = (trial >= nn_q);
  assign rem_d  = div_ge ? (trial - nn_q) : trial;
  assign quo_d  = {quo_q[QuotW-2:0], div_ge};

  // One square-root step
  assign sq_try = res_q + {1'b0, bit_q};
  assign sq_ge  = ({1'b0, x_q} >= sq_try);

  assign pop_o    = (state_q == ST_IDLE) & ~q_stat_i.empty;
  assign out_free = ~out_vld_q | out_o.ready;

  // Result word
  assign out_o.valid           = out_vld_q;
  assign out_o.variance_scaled = var_q;
  assign out_o.std_dev_scaled  = std_q;
  assign out_o.sample_count    = cnt_out_q;
  assign out_o.too_many        = ovf_out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      set_q     <= '0;
      p1_q      <= '0;
      p2_q      <= '0;
      nn_q      <= '0;
      div_q     <= '0;
      rem_q     <= '0;
      quo_q     <= '0;
      it_q      <= '0;
      x_q       <= '0;
      res_q     <= '0;
      bit_q     <= '0;
      out_vld_q <= 1'b0;
      var_q     <= '0;
      std_q     <= '0;
      cnt_out_q <= '0;
      ovf_out_q <= 1'b0;
    end else begin
      // new word loaded, or word taken by the receiver
      if (state_q == ST_DONE && out_free) begin
        out_vld_q <= 1'b1;
      end else if (out_vld_q && out_o.ready) begin
        out_vld_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (pop_o) begin
            set_q   <= pop_data_i;
            state_q <= ST_MUL;
          end
        end
        ST_MUL: begin
          p1_q    <= set_q.count * set_q.sq_sum;
          p2_q    <= abs_sum[MagW-1:0] * abs_sum[MagW-1:0];
          nn_q    <= set_q.count * set_q.count;
          state_q <= ST_SUB;
        end
        ST_SUB: begin
          div_q   <= {DW'(p1_q - ProdW'(p2_q)), {(2*FracW){1'b0}}};
          rem_q   <= '0;
          quo_q   <= '0;
          it_q    <= '0;
          state_q <= ST_DIV;
        end
        ST_DIV: begin
          div_q <= {div_q[DivInW-2:0], 1'b0};
          rem_q <= rem_d;
          quo_q <= quo_d;
          it_q  <= it_q + ItW'(1);
          if (it_q == ItW'(DivInW - 1)) begin
            x_q     <= quo_d;
            res_q   <= '0;
            bit_q   <= {1'b1, {(QuotW-1){1'b0}}};
            state_q <= ST_SQRT;
          end
        end
        ST_SQRT: begin
          if (sq_ge) begin
            x_q   <= x_q - sq_try[QuotW-1:0];
            res_q <= (res_q >> 1) + {1'b0, bit_q};
          end else begin
            res_q <= res_q >> 1;
          end
          bit_q <= bit_q >> 2;
          if (bit_q[0]) begin
            state_q <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (out_free) begin
            var_q     <= quo_q[QuotW-1:FracW];
            std_q     <= res_q[StdW-1:0];
            cnt_out_q <= set_q.count;
            ovf_out_q <= set_q.overflow;
            state_q   <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // Partial remainder stays below the divisor
  a_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV && it_q != '0) |-> rem_q < nn_q)
    else $error("division remainder out of range");

  // A set always holds at least one sample
  a_cnt_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q |-> cnt_out_q != '0)
    else $error("result with empty set");

  // A popped set starts the multiply step
  a_pop_mul: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |=> state_q == ST_MUL)
    else $error("pop without start");

endmodule

// ===== hdl/population_variance_stddev_core.sv =====
// ----------------------------------------------------------------------------
// population_variance_stddev_core
// Population variance and standard deviation of sets of signed samples.
// ----------------------------------------------------------------------------
// Usage:
//   sample_i carries one signed 16-bit sample per word; last_sample closes the
//   set. result_o gives one word per set: variance and standard deviation,
//   both with 8 fraction bits and rounded down, the sample count and a flag
//   for samples dropped past 1024 in the set.
//   The front end takes one sample word per cycle. At a closing sample the
//   set totals go into a two-entry queue; sample_i.ready drops only while that
//   queue is full.
//   The back end works on one set at a time: pop, a multiply step, a
//   subtract step, one-bit division by N^2, one-bit square root and a
//   load of the result register, then it pops the next set. Short sets are
//   limited by this divide and root sequence.
//   When the receiver stalls, the result register holds its word; the back
//   end finishes the next set and waits, and the queue then backs up into
//   the sample channel.
//   Reset clears the accumulators, the queue and the result register.
// ----------------------------------------------------------------------------
module population_variance_stddev_core (
  input  logic      clk_i,
  input  logic      rst_ni,
  pvs_in_if.sink    sample_i,
  pvs_out_if.source result_o
);
  import pvs_pkg::*;

  logic        push;
  logic        pop;
  set_sums_t   push_data;
  set_sums_t   pop_data;
  queue_stat_t q_stat;

  pvs_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (sample_i),
    .q_stat_i    (q_stat),
    .push_o      (push),
    .push_data_o (push_data)
  );

  pvs_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .pop_i       (pop),
    .pop_data_o  (pop_data),
    .stat_o      (q_stat)
  );

  pvs_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .pop_data_i (pop_data),
    .q_stat_i   (q_stat),
    .pop_o      (pop),
    .out_o      (result_o)
  );

endmodule

// ===== bench/population_variance_stddev_core_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// population_variance_stddev_core_tb
// Self-checking bench for the variance / standard deviation core.
// ----------------------------------------------------------------------------
// Sample words go in through a valid/ready source with random gaps. Each
// accepted word updates a bench copy of the set totals, and each closing word
// queues the expected result. A separate process takes result words with
// random stalls and compares them with the oldest expected result. Sets cover
// single samples, the extremes of the sample range, a set past the length
// limit, a full drain of the core, and random sets of varied length and
// content.
// ----------------------------------------------------------------------------
module population_variance_stddev_core_tb;
  import pvs_pkg::*;

  typedef logic signed [SampleW-1:0] sample_t;

  // Expected contents of one result word
  typedef struct packed {
    logic [VarW-1:0] variance;
    logic [StdW-1:0] std_dev;
    logic [CntW-1:0] count;
    logic            too_many;
  } set_stats_t;

  // Value patterns for random sets
  typedef enum int unsigned {
    FillFull,
    FillExtreme,
    FillSmall,
    FillConst
  } fill_t;

  localparam sample_t     SampleMin   = {1'b1, {(SampleW-1){1'b0}}};
  localparam sample_t     SampleMax   = {1'b0, {(SampleW-1){1'b1}}};
  localparam int unsigned ReportLimit = 10;
  localparam int unsigned StallLimit  = 4000;
  localparam int unsigned RandomWords = 250;
  localparam int unsigned TailCycles  = 250;

  logic clk_i = 1'b0;
  logic rst_ni;

  pvs_in_if  sample_ch ();
  pvs_out_if result_ch ();

  population_variance_stddev_core u_top (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .sample_i (sample_ch),
    .result_o (result_ch)
  );

  // Bench copy of the set totals
  logic [CntW-1:0]        set_count;
  logic signed [SumW-1:0] set_sum;
  logic [SqW-1:0]         set_sq_sum;
  logic                   set_dropped;

  set_stats_t  stats_due[$];
  int unsigned fail_count  = 0;
  int unsigned idle_cycles = 0;
  bit          send_fast   = 1'b0;
  bit          recv_fast   = 1'b0;

  // Clock
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Floor of the square root, one result bit per pass
  function automatic logic [StdW-1:0] floor_sqrt(input logic [63:0] x);
    logic [63:0] root;
    logic [63:0] trial;
    root = '0;
    for (int b = 31; b >= 0; b--) begin
      trial = root | (64'd1 << b);
      if (trial * trial <= x) root = trial;
    end
    return root[StdW-1:0];
  endfunction

  // Variance and deviation of the set held so far
  function automatic set_stats_t close_set_stats();
    logic [127:0]    n, sq, s1, d, nn, v8, v16;
    logic [SumW-1:0] sum_mag;
    set_stats_t      r;
    sum_mag = set_sum[SumW-1] ? -set_sum : set_sum;
    n   = 128'(set_count);
    sq  = 128'(set_sq_sum);
    s1  = 128'(sum_mag);
    d   = n * sq - s1 * s1;
    nn  = n * n;
    v8  = (d << FracW) / nn;
    v16 = (d << (2 * FracW)) / nn;
    r.variance = v8[VarW-1:0];
    r.std_dev  = floor_sqrt(v16[63:0]);
    r.count    = set_count;
    r.too_many = set_dropped;
    return r;
  endfunction

  // Fold one accepted word into the totals; a closing word queues a result
  task automatic take_sample(input sample_t s, input logic last);
    logic signed [2*SampleW-1:0] sq_term;
    sq_term = s * s;
    if (set_count < CntW'(MaxSamples)) begin
      set_count  = set_count + CntW'(1);
      set_sum    = set_sum + SumW'(s);
      set_sq_sum = set_sq_sum + SqW'(unsigned'(sq_term));
    end else begin
      set_dropped = 1'b1;
    end
    if (last) begin
      stats_due.push_back(close_set_stats());
      set_count   = '0;
      set_sum     = '0;
      set_sq_sum  = '0;
      set_dropped = 1'b0;
    end
  endtask

  // Send one sample word; valid stays high afterwards until the next call
  task automatic send_word(input sample_t s, input logic last);
    int unsigned gap;
    gap = send_fast ? 0 : $urandom_range(0, 15);
    if (gap > 0) begin
      sample_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    sample_ch.valid       <= 1'b1;
    sample_ch.sample      <= s;
    sample_ch.last_sample <= last;
    @(posedge clk_i);
    while (sample_ch.ready !== 1'b1) @(posedge clk_i);
    take_sample(s, last);
  endtask

  function automatic sample_t draw_sample(input fill_t fill, input sample_t fixed);
    sample_t pool[6];
    pool = '{SampleMin, SampleMin + sample_t'(1), sample_t'(-1), sample_t'(0),
             sample_t'(1), SampleMax};
    case (fill)
      FillFull:    return sample_t'($urandom);
      FillExtreme: return pool[$urandom_range(0, 5)];
      FillSmall:   return sample_t'(int'($urandom_range(0, 16)) - 8);
      default:     return fixed;
    endcase
  endfunction

  task automatic send_set(input int unsigned len, input fill_t fill);
    sample_t fixed;
    fixed = sample_t'($urandom);
    for (int unsigned i = 0; i < len; i++) begin
      send_word(draw_sample(fill, fixed), i == len - 1);
    end
  endtask

  // Hold the sample side idle until every queued result has come back
  task automatic wait_for_results();
    sample_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (stats_due.size() != 0) @(posedge clk_i);
  endtask

  // Sets of one sample: variance and deviation are zero
  task automatic test_single_sample_sets();
    send_word(SampleMin, 1'b1);
    send_word(SampleMax, 1'b1);
    send_word(sample_t'(0), 1'b1);
    send_word(sample_t'(-1), 1'b1);
  endtask

  // Short sets at the ends of the sample range and with alternating bits
  task automatic test_short_sets();
    send_word(SampleMin, 1'b0);
    send_word(SampleMax, 1'b1);
    repeat (2) send_word(SampleMax, 1'b0);
    send_word(SampleMax, 1'b1);
    send_word(sample_t'(1), 1'b0);
    send_word(sample_t'(-1), 1'b0);
    send_word(sample_t'(1), 1'b0);
    send_word(sample_t'(-1), 1'b0);
    send_word(sample_t'(0), 1'b1);
    send_word(16'sh5555, 1'b0);
    send_word(16'shAAAA, 1'b1);
    repeat (2) send_word(SampleMin, 1'b0);
    send_word(SampleMin, 1'b1);
  endtask

  // Set past the length limit: alternating extremes fill it for the largest
  // variance, and the closing word is dropped
  task automatic test_long_sets();
    send_fast = 1'b1;
    recv_fast = 1'b1;
    for (int unsigned i = 0; i <= MaxSamples; i++) begin
      send_word(i[0] ? SampleMax : SampleMin, i == MaxSamples);
    end
    send_fast = 1'b0;
    recv_fast = 1'b0;
  endtask

  // Let the core drain completely, then carry on
  task automatic test_drain_pause();
    send_set(3, FillFull);
    send_set(1, FillExtreme);
    wait_for_results();
    send_fast = 1'b1;
    send_set(2, FillFull);
    send_set(5, FillSmall);
    send_fast = 1'b0;
    wait_for_results();
  endtask

  // Random sets, mostly short, with a few long ones
  task automatic test_random_sets();
    int unsigned sent;
    int unsigned len;
    int unsigned pick;
    sent = 0;
    while (sent < RandomWords) begin
      pick = $urandom_range(0, 9);
      if (pick < 7)      len = $urandom_range(1, 8);
      else if (pick < 9) len = $urandom_range(9, 40);
      else               len = $urandom_range(41, 150);
      send_fast = ($urandom_range(0, 3) == 0);
      recv_fast = ($urandom_range(0, 3) == 0);
      send_set(len, fill_t'($urandom_range(0, 3)));
      sent += len;
      if ($urandom_range(0, 19) == 0) wait_for_results();
    end
    send_fast = 1'b0;
    recv_fast = 1'b0;
  endtask

  // Stimulus
  initial begin
    set_count   = '0;
    set_sum     = '0;
    set_sq_sum  = '0;
    set_dropped = 1'b0;
    rst_ni                <= 1'b0;
    sample_ch.valid       <= 1'b0;
    sample_ch.sample      <= '0;
    sample_ch.last_sample <= 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_single_sample_sets();
    test_short_sets();
    test_long_sets();
    test_drain_pause();
    test_random_sets();

    wait_for_results();
    repeat (TailCycles) @(posedge clk_i);
    if (fail_count == 0 && stats_due.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Result side: random stalls, compare each word with the oldest expectation
  initial begin : result_checker
    set_stats_t  got;
    set_stats_t  want;
    int unsigned stall;
    result_ch.ready <= 1'b0;
    @(posedge clk_i);
    while (rst_ni !== 1'b1) @(posedge clk_i);
    forever begin
      stall = recv_fast ? 0 : $urandom_range(0, 15);
      if (stall > 0) begin
        result_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      result_ch.ready <= 1'b1;
      @(posedge clk_i);
      while (result_ch.valid !== 1'b1) @(posedge clk_i);
      got.variance = result_ch.variance_scaled;
      got.std_dev  = result_ch.std_dev_scaled;
      got.count    = result_ch.sample_count;
      got.too_many = result_ch.too_many;
      if (stats_due.size() == 0) begin
        fail_count++;
        if (fail_count <= ReportLimit) begin
          $display("unexpected result word: var %0d std %0d n %0d dropped %0b",
                   got.variance, got.std_dev, got.count, got.too_many);
        end
      end else begin
        want = stats_due.pop_front();
        if (got !== want) begin
          fail_count++;
          if (fail_count <= ReportLimit) begin
            $display("result mismatch: expected var %0d std %0d n %0d dropped %0b",
                     want.variance, want.std_dev, want.count, want.too_many);
            $display("                 got      var %0d std %0d n %0d dropped %0b",
                     got.variance, got.std_dev, got.count, got.too_many);
          end
        end
      end
    end
  end

  // Watchdog: too long without a word moving on either side
  always @(posedge clk_i) begin
    if (rst_ni !== 1'b1) begin
      idle_cycles <= 0;
    end else if ((sample_ch.valid && sample_ch.ready) ||
                 (result_ch.valid && result_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= StallLimit) begin
      $display("Simulation FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule
